// File: sv/dbcs_pkg.sv
// Shared types and constants for the double-byte glyph address generator.
// No dependencies.
`timescale 1ns / 1ps

package dbcs_pkg;

   // encoding_mode register codes
   typedef enum logic [1:0] {
      ENC_NONE = 2'd0,
      ENC_BIG5 = 2'd1,
      ENC_GB   = 2'd2,
      ENC_JIS  = 2'd3
   } encoding_type;

   // row pitch selected for the row multiply
   typedef enum logic [1:0] {
      ROW_94  = 2'd0,
      ROW_157 = 2'd1,
      ROW_188 = 2'd2
   } row_width_type;

   localparam logic [3:0]  GLYPH_PIXELS   = 4'd12;

   localparam logic [7:0]  BIG5_LEAD_LO   = 8'hA1;
   localparam logic [7:0]  BIG5_LEAD_HI   = 8'hF9;
   localparam logic [7:0]  BIG5_MAIN_LEAD = 8'd164;
   localparam logic [7:0]  BIG5_SYM_LEAD  = 8'd161;
   localparam logic [7:0]  GB_LEAD_HI     = 8'hF7;
   localparam logic [7:0]  EUC_LO         = 8'hA1;
   localparam logic [7:0]  EUC_HI         = 8'hFE;
   localparam logic [7:0]  SJIS_TRAIL_LO  = 8'h40;
   localparam logic [7:0]  SJIS_TRAIL_HI  = 8'hFC;
   localparam logic [7:0]  TRAIL_DEL      = 8'h7F;
   localparam logic [7:0]  BIG5_TRAIL_HI1 = 8'h7E;
   localparam logic [7:0]  SJIS_LEAD1_LO  = 8'h81;
   localparam logic [7:0]  SJIS_LEAD1_HI  = 8'h9F;
   localparam logic [7:0]  SJIS_LEAD2_LO  = 8'hE0;
   localparam logic [7:0]  SJIS_LEAD2_HI  = 8'hEF;
   localparam logic [7:0]  SJIS_PAIR2     = 8'd31;

   localparam logic [13:0] BIG5_SYM_BASE  = 14'd13094;
   localparam logic [13:0] BIG5_GAP_START = 14'd5809;
   localparam logic [13:0] BIG5_GAP_SIZE  = 14'd408;

   // decoded item between stage 1 and stage 2
   typedef struct packed {
      logic          core;
      logic          supported;
      logic          ok;
      logic          jis;
      logic          sym;
      logic          gap;
      row_width_type sel;
      logic [6:0]    row;
      logic [7:0]    col;
   } decode_type;

endpackage

// File: sv/dbcs_glyph_address_generator_top.sv
// Top level of the double-byte glyph address generator: decode, row multiply,
// gap fold and ROM offset in a four-stage pipeline. Depends on dbcs_pkg.
`timescale 1ns / 1ps

// One character code enters per cycle: busy is always low, so a beat is taken
// at every clock edge where start is high. Its result goes through the s1 to s4
// registers to rsp_ ports, marked by rsp_valid for one cycle; the receiver cannot
// stall, and the pipeline never holds. Stages: byte decode and range check,
// row times pitch (157, 94 or 188) plus column, Big5 gap removal and invalid
// zeroing, then the ROM offset multiply (x18, or x12 for JIS). The
// encoding_mode register is written through the csr_ channel, which is always
// ready; write it only while no beat is in flight.
module dbcs_glyph_address_generator_top
   import dbcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_char_code,
   output logic        rsp_valid,
   output logic        rsp_use_core_font,
   output logic [13:0] rsp_glyph_index,
   output logic [17:0] rsp_glyph_offset,
   output logic [3:0]  rsp_glyph_width,
   output logic [3:0]  rsp_glyph_height,
   output logic [3:0]  rsp_glyph_baseline,
   output logic        rsp_out_of_range,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_encoding_mode
);

   encoding_type mode_ff;

   // stage 1: decoded bytes
   logic       s1_valid_ff;
   decode_type s1_ff, s1_in;

   // stage 2: linear sequence number
   logic        s2_valid_ff;
   logic        s2_core_ff, s2_supported_ff, s2_ok_ff, s2_jis_ff, s2_gap_ff;
   logic [13:0] s2_seq_ff, s2_seq_in;

   // stage 3: glyph index
   logic        s3_valid_ff;
   logic        s3_core_ff, s3_supported_ff, s3_ok_ff, s3_jis_ff;
   logic [13:0] s3_idx_ff, s3_idx_in;

   // stage 4: output registers
   logic        s4_valid_ff;
   logic        s4_core_ff, s4_supported_ff, s4_ok_ff;
   logic [13:0] s4_idx_ff;
   logic [17:0] s4_off_ff, s4_off_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // ---------------- stage 1: decode ----------------
   logic [7:0]  hi, lo;
   logic [7:0]  row_full;
   logic        euc_hi, euc_lo, sjis_lo, lead1, lead2;

   assign hi = req_char_code[15:8];
   assign lo = req_char_code[7:0];

   always_comb begin
      euc_hi   = (hi >= EUC_LO) && (hi <= EUC_HI);
      euc_lo   = (lo >= EUC_LO) && (lo <= EUC_HI);
      sjis_lo  = (lo >= SJIS_TRAIL_LO) && (lo <= SJIS_TRAIL_HI) && (lo != TRAIL_DEL);
      lead1    = (hi >= SJIS_LEAD1_LO) && (hi <= SJIS_LEAD1_HI);
      lead2    = (hi >= SJIS_LEAD2_LO) && (hi <= SJIS_LEAD2_HI);
      row_full = 8'd0;

      s1_in           = '0;
      s1_in.sel       = ROW_94;
      s1_in.core      = (hi == 8'd0);
      s1_in.supported = 1'b0;

      unique case (mode_ff)
         ENC_BIG5: begin
            s1_in.supported = 1'b1;
            s1_in.sel       = ROW_157;
            s1_in.ok = (hi >= BIG5_LEAD_LO) && (hi <= BIG5_LEAD_HI) &&
                       (((lo >= SJIS_TRAIL_LO) && (lo <= BIG5_TRAIL_HI1)) || euc_lo);
            // fold the two trail ranges into one 157-wide column
            s1_in.col = (lo < TRAIL_DEL) ? lo - 8'd64 : lo - 8'd98;
            if (hi >= BIG5_MAIN_LEAD) begin
               row_full  = hi - BIG5_MAIN_LEAD;
               s1_in.gap = 1'b1;
            end else begin
               row_full  = hi - BIG5_SYM_LEAD;
               s1_in.sym = 1'b1;
            end
         end
         ENC_GB: begin
            s1_in.supported = 1'b1;
            s1_in.ok  = (hi >= EUC_LO) && (hi <= GB_LEAD_HI) && euc_lo;
            row_full  = hi - EUC_LO;
            s1_in.col = lo - EUC_LO;
         end
         ENC_JIS: begin
            s1_in.supported = 1'b1;
            s1_in.jis       = 1'b1;
            if (euc_hi && euc_lo) begin
               // EUC wins where the two forms overlap
               s1_in.ok  = 1'b1;
               row_full  = hi - EUC_LO;
               s1_in.col = lo - EUC_LO;
            end else begin
               s1_in.sel = ROW_188;
               s1_in.ok  = sjis_lo && (lead1 || lead2);
               row_full  = lead1 ? hi - SJIS_LEAD1_LO : hi - SJIS_LEAD2_LO + SJIS_PAIR2;
               s1_in.col = (lo < 8'h80) ? lo - 8'h40 : lo - 8'h41;
            end
         end
         default: begin
            s1_in.supported = 1'b0;
         end
      endcase
      s1_in.row = row_full[6:0];
   end

   // ---------------- stage 2: row multiply ----------------
   logic [14:0] prod;
   logic [14:0] seq_sum;

   always_comb begin
      unique case (s1_ff.sel)
         ROW_157: prod = 15'({8'd0, s1_ff.row} * 15'd157);
         ROW_188: prod = 15'({8'd0, s1_ff.row} * 15'd188);
         default: prod = 15'({8'd0, s1_ff.row} * 15'd94);
      endcase
      seq_sum = prod + {7'd0, s1_ff.col} + (s1_ff.sym ? {1'b0, BIG5_SYM_BASE} : 15'd0);
      s2_seq_in = seq_sum[13:0];
   end

   // ---------------- stage 3: gap fold and repair ----------------
   always_comb begin
      // drop the index to zero unless a valid double-byte glyph
      if (s2_core_ff || !s2_supported_ff || !s2_ok_ff) begin
         s3_idx_in = 14'd0;
      end else if (s2_gap_ff && (s2_seq_ff >= BIG5_GAP_START)) begin
         s3_idx_in = s2_seq_ff - BIG5_GAP_SIZE;
      end else begin
         s3_idx_in = s2_seq_ff;
      end
   end

   // ---------------- stage 4: ROM offset ----------------
   logic [18:0] off_full;

   always_comb begin
      off_full  = s3_jis_ff ? {5'd0, s3_idx_ff} * 19'd12 : {5'd0, s3_idx_ff} * 19'd18;
      s4_off_in = off_full[17:0];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ENC_NONE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= encoding_type'(csr_encoding_mode);
         end
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload advances every cycle; no stall exists
   always_ff @(posedge clock) begin
      s1_ff           <= s1_in;

      s2_core_ff      <= s1_ff.core;
      s2_supported_ff <= s1_ff.supported;
      s2_ok_ff        <= s1_ff.ok;
      s2_jis_ff       <= s1_ff.jis;
      s2_gap_ff       <= s1_ff.gap;
      s2_seq_ff       <= s2_seq_in;

      s3_core_ff      <= s2_core_ff;
      s3_supported_ff <= s2_supported_ff;
      s3_ok_ff        <= s2_ok_ff;
      s3_jis_ff       <= s2_jis_ff;
      s3_idx_ff       <= s3_idx_in;

      s4_core_ff      <= s3_core_ff;
      s4_supported_ff <= s3_supported_ff;
      s4_ok_ff        <= s3_ok_ff;
      s4_idx_ff       <= s3_idx_ff;
      s4_off_ff       <= s4_off_in;
   end

   // ---------------- result beat ----------------
   logic glyph_sized;
   assign glyph_sized = s4_supported_ff && !s4_core_ff;

   assign rsp_valid          = s4_valid_ff;
   assign rsp_use_core_font  = s4_core_ff;
   assign rsp_glyph_index    = s4_idx_ff;
   assign rsp_glyph_offset   = s4_off_ff;
   assign rsp_glyph_width    = glyph_sized ? GLYPH_PIXELS : 4'd0;
   assign rsp_glyph_height   = glyph_sized ? GLYPH_PIXELS : 4'd0;
   assign rsp_glyph_baseline = 4'd0;
   assign rsp_out_of_range   = glyph_sized && !s4_ok_ff;

endmodule

// File: verif/glyph_ledger_pkg.sv
// Scoreboard for the double-byte glyph address generator: predicts each glyph
// address from the character code and the encoding mode. Depends on dbcs_pkg.
`timescale 1ns / 1ps

package glyph_ledger_pkg;
   import dbcs_pkg::*;

   typedef struct packed {
      logic        use_core_font;
      logic [13:0] glyph_index;
      logic [17:0] glyph_offset;
      logic [3:0]  glyph_width;
      logic [3:0]  glyph_height;
      logic [3:0]  glyph_baseline;
      logic        out_of_range;
   } glyph_result_type;

   typedef struct packed {
      logic [15:0]      char_code;
      glyph_result_type glyph;
   } glyph_due_type;

   localparam int unsigned BIG5_PITCH      = 157;
   localparam int unsigned GB_PITCH        = 94;
   localparam int unsigned SJIS_PAIR_PITCH = 188;
   localparam int unsigned BYTE_STRIDE     = 18;
   localparam int unsigned JIS_STRIDE      = 12;
   // first column of the 0xA1..0xFE trail half in a Big5 row
   localparam int unsigned BIG5_UPPER_COL  = 63;

   class glyph_address_ledger;
      encoding_type  enc_mode;
      glyph_due_type due_q[$];
      int unsigned   mismatches;

      function new();
         enc_mode   = ENC_NONE;
         mismatches = 0;
      endfunction

      function void set_encoding(encoding_type mode);
         enc_mode = mode;
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction

      function glyph_result_type predict_glyph(logic [15:0] code);
         int unsigned      lead;
         int unsigned      trail;
         int unsigned      col;
         int unsigned      pair;
         int unsigned      num;
         int unsigned      addr;
         int unsigned      stride;
         bit               ok;
         glyph_result_type g;
         g      = '0;
         lead   = {24'd0, code[15:8]};
         trail  = {24'd0, code[7:0]};
         num    = 0;
         pair   = 0;
         col    = 0;
         stride = BYTE_STRIDE;
         ok     = 1'b0;
         if (lead == 0) begin
            g.use_core_font = 1'b1;
            return g;
         end
         case (enc_mode)
            ENC_BIG5: begin
               if (lead >= BIG5_LEAD_LO && lead <= BIG5_LEAD_HI &&
                   ((trail >= SJIS_TRAIL_LO && trail <= BIG5_TRAIL_HI1) ||
                    (trail >= EUC_LO && trail <= EUC_HI))) begin
                  ok  = 1'b1;
                  col = (trail <= BIG5_TRAIL_HI1) ? trail - SJIS_TRAIL_LO
                                                  : trail - EUC_LO + BIG5_UPPER_COL;
                  if (lead >= BIG5_MAIN_LEAD) begin
                     num = (lead - BIG5_MAIN_LEAD) * BIG5_PITCH + col;
                     if (num >= BIG5_GAP_START)
                        num = num - BIG5_GAP_SIZE;
                  end else begin
                     num = (lead - BIG5_SYM_LEAD) * BIG5_PITCH + col + BIG5_SYM_BASE;
                  end
               end
            end
            ENC_GB: begin
               if (lead >= EUC_LO && lead <= GB_LEAD_HI &&
                   trail >= EUC_LO && trail <= EUC_HI) begin
                  ok  = 1'b1;
                  num = (lead - EUC_LO) * GB_PITCH + (trail - EUC_LO);
               end
            end
            ENC_JIS: begin
               stride = JIS_STRIDE;
               if (lead >= EUC_LO && lead <= EUC_HI && trail >= EUC_LO && trail <= EUC_HI) begin
                  ok  = 1'b1;
                  num = (lead - EUC_LO) * GB_PITCH + (trail - EUC_LO);
               end else if (trail >= SJIS_TRAIL_LO && trail <= SJIS_TRAIL_HI &&
                            trail != TRAIL_DEL) begin
                  col = (trail < TRAIL_DEL) ? trail - SJIS_TRAIL_LO : trail - SJIS_TRAIL_LO - 1;
                  if (lead >= SJIS_LEAD1_LO && lead <= SJIS_LEAD1_HI) begin
                     ok   = 1'b1;
                     pair = lead - SJIS_LEAD1_LO;
                  end else if (lead >= SJIS_LEAD2_LO && lead <= SJIS_LEAD2_HI) begin
                     ok   = 1'b1;
                     pair = lead - SJIS_LEAD2_LO + SJIS_PAIR2;
                  end
                  if (ok)
                     num = pair * SJIS_PAIR_PITCH + col;
               end
            end
            default: return g;
         endcase
         if (!ok)
            num = 0;
         addr             = num * stride;
         g.glyph_index    = num[13:0];
         g.glyph_offset   = addr[17:0];
         g.glyph_width    = GLYPH_PIXELS;
         g.glyph_height   = GLYPH_PIXELS;
         g.glyph_baseline = '0;
         g.out_of_range   = !ok;
         return g;
      endfunction

      function void note_code(logic [15:0] code);
         glyph_due_type due;
         due.char_code = code;
         due.glyph     = predict_glyph(code);
         due_q.push_back(due);
      endfunction

      function void compare_field(string field, logic [15:0] code,
                                  logic [17:0] want, logic [17:0] got);
         if (got !== want) begin
            mismatches++;
            $error("code 0x%04h %s: expected 0x%0h, actual 0x%0h", code, field, want, got);
         end
      endfunction

      function void check_glyph(glyph_result_type got);
         glyph_due_type due;
         if (due_q.size() == 0) begin
            mismatches++;
            $error("result with no code waiting, glyph_index 0x%0h", got.glyph_index);
            return;
         end
         due = due_q.pop_front();
         compare_field("use_core_font", due.char_code, 18'(due.glyph.use_core_font),
                       18'(got.use_core_font));
         compare_field("glyph_index", due.char_code, 18'(due.glyph.glyph_index),
                       18'(got.glyph_index));
         compare_field("glyph_offset", due.char_code, due.glyph.glyph_offset, got.glyph_offset);
         compare_field("glyph_width", due.char_code, 18'(due.glyph.glyph_width),
                       18'(got.glyph_width));
         compare_field("glyph_height", due.char_code, 18'(due.glyph.glyph_height),
                       18'(got.glyph_height));
         compare_field("glyph_baseline", due.char_code, 18'(due.glyph.glyph_baseline),
                       18'(got.glyph_baseline));
         compare_field("out_of_range", due.char_code, 18'(due.glyph.out_of_range),
                       18'(got.out_of_range));
      endfunction

      function bit all_matched();
         if (due_q.size() != 0)
            $error("%0d results never arrived", due_q.size());
         return mismatches == 0 && due_q.size() == 0;
      endfunction
   endclass

endpackage

// File: verif/tb_top.sv
// Testbench top for the double-byte glyph address generator: directed and random
// character codes under every encoding mode. Depends on dbcs_pkg and glyph_ledger_pkg.
`timescale 1ns / 1ps

module tb_top;
   import dbcs_pkg::*;
   import glyph_ledger_pkg::*;

   localparam int  CODES_PER_PHASE = 152;
   localparam int  RANDOM_PHASES   = 12;
   // pipeline is four deep; give it a little more before touching the mode
   localparam int  DRAIN_CYCLES    = 8;
   localparam real TIMEOUT_NS      = 10_000_000.0;

   // bytes on or next to every range boundary of the three encodings
   localparam logic [7:0] BOUNDARY_BYTES [0:23] = '{
      8'h00, 8'h3F, 8'h40, 8'h7E, 8'h7F, 8'h80, 8'h81, 8'h9F,
      8'hA0, 8'hA1, 8'hA3, 8'hA4, 8'hC8, 8'hC9, 8'hDF, 8'hE0,
      8'hEF, 8'hF0, 8'hF7, 8'hF8, 8'hF9, 8'hFA, 8'hFC, 8'hFF
   };

   logic        clock;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic        busy;
   logic [15:0] req_char_code     = '0;
   logic        rsp_valid;
   logic        rsp_use_core_font;
   logic [13:0] rsp_glyph_index;
   logic [17:0] rsp_glyph_offset;
   logic [3:0]  rsp_glyph_width;
   logic [3:0]  rsp_glyph_height;
   logic [3:0]  rsp_glyph_baseline;
   logic        rsp_out_of_range;
   logic        csr_valid         = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_encoding_mode = ENC_NONE;

   glyph_address_ledger ledger;
   glyph_result_type    rsp_glyph;

   dbcs_glyph_address_generator_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_use_core_font  (rsp_use_core_font),
      .rsp_glyph_index    (rsp_glyph_index),
      .rsp_glyph_offset   (rsp_glyph_offset),
      .rsp_glyph_width    (rsp_glyph_width),
      .rsp_glyph_height   (rsp_glyph_height),
      .rsp_glyph_baseline (rsp_glyph_baseline),
      .rsp_out_of_range   (rsp_out_of_range),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_encoding_mode  (csr_encoding_mode)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   assign rsp_glyph = '{use_core_font:  rsp_use_core_font,
                        glyph_index:    rsp_glyph_index,
                        glyph_offset:   rsp_glyph_offset,
                        glyph_width:    rsp_glyph_width,
                        glyph_height:   rsp_glyph_height,
                        glyph_baseline: rsp_glyph_baseline,
                        out_of_range:   rsp_out_of_range};

   // The receiver cannot stall: take every strobed beat at the edge that ends it.
   // Outputs read here still hold their pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         ledger.check_glyph(rsp_glyph);
   end

   // Present one code, hold it until the edge where start meets a low busy,
   // then log the beat. Leaves start high so back-to-back beats need no
   // second assignment in the same step.
   task automatic send_code(input logic [15:0] code);
      start         <= 1'b1;
      req_char_code <= code;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      ledger.note_code(code);
   endtask

   // Drop start for an idle burst of random length, pct percent of the time.
   task automatic idle_burst(input int unsigned pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10))
            @(posedge clock);
      end
   endtask

   // Drain the pipeline, then write the mode through the csr channel.
   task automatic write_mode(input encoding_type mode);
      start <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      csr_valid         <= 1'b1;
      csr_encoding_mode <= mode;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      ledger.set_encoding(mode);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] boundary_byte();
      return BOUNDARY_BYTES[5'($urandom_range(0, 23))];
   endfunction

   // Mostly well-formed codes for the active encoding; the rest is core-font
   // codes, boundary bytes and plain noise over all 16 bits.
   function automatic logic [15:0] pick_code(input encoding_type mode);
      int unsigned roll;
      logic [7:0]  lead;
      logic [7:0]  trail;
      roll  = $urandom_range(0, 99);
      lead  = 8'($urandom_range(0, 255));
      trail = 8'($urandom_range(0, 255));
      if (roll < 10)
         return {8'h00, trail};
      if (roll < 25)
         return {boundary_byte(), boundary_byte()};
      if (roll < 40)
         return 16'($urandom_range(0, 16'hFFFF));
      case (mode)
         ENC_BIG5: begin
            lead  = 8'($urandom_range(BIG5_LEAD_LO, BIG5_LEAD_HI));
            trail = $urandom_range(0, 1) ? 8'($urandom_range(SJIS_TRAIL_LO, BIG5_TRAIL_HI1))
                                         : 8'($urandom_range(EUC_LO, EUC_HI));
         end
         ENC_GB: begin
            lead  = 8'($urandom_range(EUC_LO, GB_LEAD_HI));
            trail = 8'($urandom_range(EUC_LO, EUC_HI));
         end
         ENC_JIS: begin
            if ($urandom_range(0, 1)) begin
               lead  = 8'($urandom_range(EUC_LO, EUC_HI));
               trail = 8'($urandom_range(EUC_LO, EUC_HI));
            end else begin
               lead  = $urandom_range(0, 1) ? 8'($urandom_range(SJIS_LEAD1_LO, SJIS_LEAD1_HI))
                                            : 8'($urandom_range(SJIS_LEAD2_LO, SJIS_LEAD2_HI));
               trail = 8'($urandom_range(SJIS_TRAIL_LO, SJIS_TRAIL_HI));
               if (trail == TRAIL_DEL)
                  trail = TRAIL_DEL + 8'd1;
            end
         end
         default: ;
      endcase
      return {lead, trail};
   endfunction

   // Directed codes, each paired with the mode it exercises: core-font edge,
   // unsupported mode, Big5 symbol rows, gap fold on both sides of index 5809,
   // GB2312 grid corners, JIS EUC versus Shift-JIS and the second lead block.
   typedef struct packed {
      encoding_type mode;
      logic [15:0]  code;
   } directed_code_type;

   localparam int DIRECTED_COUNT = 30;
   localparam directed_code_type DIRECTED [0:DIRECTED_COUNT-1] = '{
      '{ENC_NONE, 16'h0000}, '{ENC_NONE, 16'h00FF}, '{ENC_NONE, 16'h0100},
      '{ENC_NONE, 16'hFFFF},
      '{ENC_BIG5, 16'h00FF}, '{ENC_BIG5, 16'h0100}, '{ENC_BIG5, 16'hA140},
      '{ENC_BIG5, 16'hA3FE}, '{ENC_BIG5, 16'hA440}, '{ENC_BIG5, 16'hC8FE},
      '{ENC_BIG5, 16'hC940}, '{ENC_BIG5, 16'hF9FE}, '{ENC_BIG5, 16'hA17F},
      '{ENC_BIG5, 16'hA1A0}, '{ENC_BIG5, 16'hA0A1}, '{ENC_BIG5, 16'hFA40},
      '{ENC_GB,   16'hA1A1}, '{ENC_GB,   16'hF7FE}, '{ENC_GB,   16'hF8A1},
      '{ENC_GB,   16'hA1FF},
      '{ENC_JIS,  16'hA1A1}, '{ENC_JIS,  16'hFEFE}, '{ENC_JIS,  16'h8140},
      '{ENC_JIS,  16'h9FFC}, '{ENC_JIS,  16'hE040}, '{ENC_JIS,  16'hEFFC},
      '{ENC_JIS,  16'h817F}, '{ENC_JIS,  16'h81FD}, '{ENC_JIS,  16'hF040},
      '{ENC_JIS,  16'hA140}
   };

   // Modes for the random phases; both extremes appear more than once.
   localparam encoding_type PHASE_MODES [0:RANDOM_PHASES-1] = '{
      ENC_BIG5, ENC_GB, ENC_JIS, ENC_NONE, ENC_JIS, ENC_BIG5,
      ENC_GB, ENC_NONE, ENC_BIG5, ENC_JIS, ENC_GB, ENC_BIG5
   };

   initial begin : stimulus
      int unsigned gap_pct;
      ledger = new();
      repeat (6)
         @(posedge clock);
      reset <= 1'b0;

      // directed part: change the mode only where the table moves on to a new one
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         if (DIRECTED[i].mode != ledger.enc_mode)
            write_mode(DIRECTED[i].mode);
         send_code(DIRECTED[i].code);
         idle_burst(30);
      end

      // random part: one mode per phase; the last two phases run without gaps
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_mode(PHASE_MODES[p]);
         if (p >= RANDOM_PHASES - 2)
            gap_pct = 0;
         else
            gap_pct = $urandom_range(0, 1) ? $urandom_range(5, 50) : 0;
         for (int n = 0; n < CODES_PER_PHASE; n++) begin
            send_code(pick_code(PHASE_MODES[p]));
            idle_burst(gap_pct);
         end
      end

      // drain: wait for every expected beat, then a few more cycles for strays
      start <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (ledger.all_matched())
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
